// ===== rtl/obla_pkg.sv =====
// obla_pkg: shared types, widths and helper functions for the order book level aggregator
// no dependencies; imported by obla_ctrl, obla_dp, order_book_level_aggregator_unit and the bench
`timescale 1ns / 1ps

package obla_pkg;

   localparam int PRICE_W     = 12;
   localparam int AMT_W       = 24;
   localparam int LPC         = 32;
   localparam int POS_W       = 5;
   localparam int CHUNK_W     = PRICE_W - POS_W;
   localparam int NUM_CHUNKS  = 1 << CHUNK_W;
   localparam int NUM_LEVELS  = 1 << PRICE_W;
   localparam int CAMT_W      = AMT_W + POS_W;
   localparam int PROD_W      = AMT_W + PRICE_W;
   localparam int CCOST_W     = PROD_W + POS_W;
   localparam int COST_W      = 48;
   localparam int TARGET_W    = 32;
   localparam int MODE_W      = 2;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 128;

   localparam logic [TARGET_W-1:0] TARGET_RESET = 32'd100;
   localparam logic [AMT_W-1:0]    AMT_MAX      = {AMT_W{1'b1}};

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD    = 2'd0,
      MODE_REMOVE = 2'd1,
      MODE_BEST   = 2'd2,
      MODE_COST   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPD_RD,
      ST_UPD_CALC,
      ST_UPD_WR,
      ST_SCAN,
      ST_WALK,
      ST_FLUSH,
      ST_LAST_RD,
      ST_LAST_WAIT,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clr;
      logic load;
      logic upd;
      logic upd_calc;
      logic upd_wr;
      logic scan;
      logic walk;
      logic last_rd;
      logic last_eval;
      logic latch;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic     clr_done;
      logic     best_hit;
      logic     scan_end;
      logic     go_walk;
      logic     exact;
      logic     walk_done;
      logic     short_any;
      logic     rsp_hold;
      mode_type mode;
   } status_type;

   // one chunk summary entry
   typedef struct packed {
      logic [LPC-1:0]     bitmap;
      logic [CAMT_W-1:0]  amt;
      logic [CCOST_W-1:0] cost;
   } chunk_type;

   // position of the lowest set bit
   function automatic logic [POS_W-1:0] lowest_bit(input logic [LPC-1:0] map);
      logic [POS_W-1:0] pos;
      pos = '0;
      for (int i = LPC - 1; i >= 0; i--) begin
         if (map[i]) pos = POS_W'(i);
      end
      return pos;
   endfunction

   // position of the highest set bit
   function automatic logic [POS_W-1:0] highest_bit(input logic [LPC-1:0] map);
      logic [POS_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < LPC; i++) begin
         if (map[i]) pos = POS_W'(i);
      end
      return pos;
   endfunction

endpackage

// ===== rtl/obla_ctrl.sv =====
// obla_ctrl: sequencer for the order book level aggregator
// depends on obla_pkg; drives obla_dp through cmd_type and reads status_type
`timescale 1ns / 1ps

module obla_ctrl import obla_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  mode_type   req_mode,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr = 1'b1;
            if (status.clr_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               if (req_mode inside {MODE_ADD, MODE_REMOVE}) state_in = ST_UPD_RD;
               else state_in = ST_SCAN;
            end
         end
         ST_UPD_RD: begin
            cmd.upd  = 1'b1;
            state_in = ST_UPD_CALC;
         end
         ST_UPD_CALC: begin
            cmd.upd      = 1'b1;
            cmd.upd_calc = 1'b1;
            state_in     = ST_UPD_WR;
         end
         ST_UPD_WR: begin
            cmd.upd    = 1'b1;
            cmd.upd_wr = 1'b1;
            state_in   = ST_RESP;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.best_hit) begin
               state_in = ST_RESP;
            end else if (status.go_walk) begin
               state_in = ST_WALK;
            end else if (status.exact) begin
               state_in = ST_LAST_RD;
            end else if (status.scan_end) begin
               if (status.mode == MODE_COST && status.short_any) state_in = ST_LAST_RD;
               else state_in = ST_RESP;
            end
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            state_in = ST_RESP;
         end
         ST_LAST_RD: begin
            cmd.last_rd = 1'b1;
            state_in    = ST_LAST_WAIT;
         end
         ST_LAST_WAIT: begin
            cmd.last_rd   = 1'b1;
            cmd.last_eval = 1'b1;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (!status.rsp_hold) begin
               cmd.latch = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// ===== rtl/obla_dp.sv =====
// obla_dp: level and chunk memories, arithmetic and result register of the aggregator
// depends on obla_pkg; sequenced by obla_ctrl
`timescale 1ns / 1ps

module obla_dp import obla_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [MODE_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [TARGET_W-1:0]   csr_wr_data
);

   // memories
   chunk_type        chk_mem [NUM_CHUNKS];
   logic [AMT_W-1:0] lvl_mem [NUM_LEVELS];
   chunk_type        chk_rd_ff;
   logic [AMT_W-1:0] lvl_rd_ff;

   // control registers
   logic [TARGET_W-1:0] target_ff, target_in;
   logic [PRICE_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [CHUNK_W:0]    scan_cnt_ff, scan_cnt_in;
   logic                pend_v_ff, pend_v_in;
   logic [POS_W:0]      walk_cnt_ff, walk_cnt_in;
   logic                lv_v_ff, lv_v_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // payload registers
   mode_type            mode_ff, mode_in;
   logic [PRICE_W-1:0]  price_ff, price_in;
   logic [AMT_W-1:0]    amount_ff, amount_in;
   logic [CHUNK_W-1:0]  pend_idx_ff, pend_idx_in;
   logic [POS_W-1:0]    lv_pos_ff, lv_pos_in;
   logic [TARGET_W-1:0] need_ff, need_in;
   logic [COST_W-1:0]   cost_ff, cost_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic                any_ff, any_in;
   logic [PRICE_W-1:0]  last_price_ff, last_price_in;
   logic [CHUNK_W-1:0]  walk_base_ff, walk_base_in;
   logic [LPC-1:0]      walk_map_ff, walk_map_in;
   logic [AMT_W-1:0]    take_ff, take_in;
   logic [AMT_W-1:0]    lvl_new_ff, lvl_new_in;
   logic                uf_ff, uf_in;
   logic                lvl_emp_ff, lvl_emp_in;
   logic                chk_emp_ff, chk_emp_in;
   logic [PRICE_W-1:0]  best_ff, best_in;
   logic                empty_ff, empty_in;
   logic [PRICE_W-1:0]  mprice_ff, mprice_in;
   logic [AMT_W-1:0]    mused_ff, mused_in;
   logic [AMT_W-1:0]    mleft_ff, mleft_in;
   logic                short_ff, short_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // combinational helpers
   logic [CHUNK_W-1:0] chk_raddr, chk_waddr;
   logic [PRICE_W-1:0] lvl_raddr, lvl_waddr;
   logic               chk_we, lvl_we;
   chunk_type          chk_wdata, chunk_new;
   logic [AMT_W-1:0]   lvl_wdata;
   logic               is_add, cost_mode;
   logic [AMT_W-1:0]   held, room, add_take, rem_take;
   logic [LPC-1:0]     pos_mask;
   logic               scan_issue, eval_v, fits;
   logic [TARGET_W-1:0] need_after;
   logic               walk_issue, w_eval, w_lt;
   logic [PRICE_W-1:0] w_pr;
   logic [AMT_W-1:0]   mul_a;
   logic [PRICE_W-1:0] mul_b;
   logic [COST_W-1:0]  cost_out;

   // memory ports
   always_ff @(posedge clock) begin
      if (chk_we) chk_mem[chk_waddr] <= chk_wdata;
      chk_rd_ff <= chk_mem[chk_raddr];
   end

   always_ff @(posedge clock) begin
      if (lvl_we) lvl_mem[lvl_waddr] <= lvl_wdata;
      lvl_rd_ff <= lvl_mem[lvl_raddr];
   end

   // address and write selection
   always_comb begin
      chk_raddr = cmd.upd ? price_ff[PRICE_W-1:POS_W] : scan_cnt_ff[CHUNK_W-1:0];
      if (cmd.upd) lvl_raddr = price_ff;
      else if (cmd.walk) lvl_raddr = {walk_base_ff, walk_cnt_ff[POS_W-1:0]};
      else lvl_raddr = last_price_ff;
      chk_we    = (cmd.clr && clr_cnt_ff[PRICE_W-1:CHUNK_W] == '0) || cmd.upd_wr;
      chk_waddr = cmd.clr ? clr_cnt_ff[CHUNK_W-1:0] : price_ff[PRICE_W-1:POS_W];
      chk_wdata = cmd.clr ? chunk_type'('0) : chunk_new;
      lvl_we    = cmd.clr || cmd.upd_wr;
      lvl_waddr = cmd.clr ? clr_cnt_ff : price_ff;
      lvl_wdata = cmd.clr ? '0 : lvl_new_ff;
   end

   // add and remove arithmetic
   always_comb begin
      is_add    = (mode_ff == MODE_ADD);
      cost_mode = (mode_ff == MODE_COST);
      held      = lvl_rd_ff;
      room      = AMT_MAX - held;
      add_take  = (amount_ff < room) ? amount_ff : room;
      rem_take  = (amount_ff > held) ? held : amount_ff;
      pos_mask  = LPC'(1) << price_ff[POS_W-1:0];
      chunk_new = chk_rd_ff;
      if (is_add) begin
         chunk_new.amt  = chk_rd_ff.amt + CAMT_W'(take_ff);
         chunk_new.cost = chk_rd_ff.cost + CCOST_W'(prod_ff);
         if (lvl_new_ff != '0) chunk_new.bitmap = chk_rd_ff.bitmap | pos_mask;
      end else begin
         chunk_new.amt  = chk_rd_ff.amt - CAMT_W'(take_ff);
         chunk_new.cost = chk_rd_ff.cost - CCOST_W'(prod_ff);
         if (lvl_new_ff == '0) chunk_new.bitmap = chk_rd_ff.bitmap & ~pos_mask;
      end
   end

   // chunk scan and level walk decisions
   always_comb begin
      scan_issue = cmd.scan && !scan_cnt_ff[CHUNK_W];
      eval_v     = cmd.scan && pend_v_ff && (chk_rd_ff.bitmap != '0);
      fits       = TARGET_W'(chk_rd_ff.amt) <= need_ff;
      need_after = need_ff - TARGET_W'(chk_rd_ff.amt);
      walk_issue = cmd.walk && !walk_cnt_ff[POS_W];
      w_eval     = cmd.walk && lv_v_ff && walk_map_ff[lv_pos_ff];
      w_pr       = {walk_base_ff, lv_pos_ff};
      w_lt       = TARGET_W'(lvl_rd_ff) < need_ff;
      // shared multiplier operands
      if (cmd.upd_calc) begin
         mul_a = is_add ? add_take : rem_take;
         mul_b = price_ff;
      end else begin
         mul_a = w_lt ? lvl_rd_ff : need_ff[AMT_W-1:0];
         mul_b = w_pr;
      end
      status.clr_done  = cmd.clr && (clr_cnt_ff == {PRICE_W{1'b1}});
      status.best_hit  = eval_v && !cost_mode;
      status.go_walk   = eval_v && cost_mode && !fits;
      status.exact     = eval_v && cost_mode && fits && (need_after == '0);
      status.scan_end  = cmd.scan && scan_cnt_ff[CHUNK_W] && !pend_v_ff;
      status.walk_done = w_eval && !w_lt;
      status.short_any = (need_ff != '0) && any_ff;
      status.rsp_hold  = rsp_valid_ff && !rsp_tready;
      status.mode      = mode_ff;
   end

   // next values
   always_comb begin
      target_in     = target_ff;
      clr_cnt_in    = clr_cnt_ff;
      scan_cnt_in   = scan_cnt_ff;
      walk_cnt_in   = walk_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      price_in      = price_ff;
      amount_in     = amount_ff;
      need_in       = need_ff;
      any_in        = any_ff;
      last_price_in = last_price_ff;
      walk_base_in  = walk_base_ff;
      walk_map_in   = walk_map_ff;
      take_in       = take_ff;
      lvl_new_in    = lvl_new_ff;
      uf_in         = uf_ff;
      lvl_emp_in    = lvl_emp_ff;
      chk_emp_in    = chk_emp_ff;
      best_in       = best_ff;
      empty_in      = empty_ff;
      mprice_in     = mprice_ff;
      mused_in      = mused_ff;
      mleft_in      = mleft_ff;
      short_in      = short_ff;
      rsp_data_in   = rsp_data_ff;
      cost_out      = cost_mode ? cost_ff : '0;

      // read pipelines
      pend_v_in   = scan_issue;
      pend_idx_in = scan_cnt_ff[CHUNK_W-1:0];
      if (scan_issue) scan_cnt_in = scan_cnt_ff + 1'b1;
      lv_v_in   = walk_issue;
      lv_pos_in = walk_cnt_ff[POS_W-1:0];
      if (walk_issue) walk_cnt_in = walk_cnt_ff + 1'b1;

      // product and running cost
      prod_in = (cmd.upd_calc || w_eval) ? PROD_W'(mul_a * mul_b) : '0;
      cost_in = cost_ff + COST_W'(prod_ff);

      if (csr_wr_en) target_in = csr_wr_data;
      if (cmd.clr) clr_cnt_in = clr_cnt_ff + 1'b1;

      // capture a new word
      if (cmd.load) begin
         mode_in       = mode_type'(req_tuser);
         price_in      = req_tdata[PRICE_W-1:0];
         amount_in     = req_tdata[PRICE_W+AMT_W-1:PRICE_W];
         need_in       = target_ff;
         cost_in       = '0;
         any_in        = 1'b0;
         last_price_in = '0;
         scan_cnt_in   = '0;
         uf_in         = 1'b0;
         lvl_emp_in    = 1'b0;
         chk_emp_in    = 1'b0;
         best_in       = '0;
         empty_in      = 1'b0;
         mprice_in     = '0;
         mused_in      = '0;
         mleft_in      = '0;
         short_in      = 1'b0;
      end

      // level update
      if (cmd.upd_calc) begin
         take_in    = is_add ? add_take : rem_take;
         lvl_new_in = is_add ? held + add_take : held - rem_take;
         uf_in      = !is_add && (amount_ff > held);
      end
      if (cmd.upd_wr) begin
         lvl_emp_in = !is_add && (lvl_new_ff == '0);
         chk_emp_in = !is_add && (lvl_new_ff == '0) && (chunk_new.amt == '0);
      end

      // best price, empty book and short fill at the end of the scan
      if (status.best_hit) best_in = {pend_idx_ff, lowest_bit(chk_rd_ff.bitmap)};
      if (status.scan_end && !cost_mode) empty_in = 1'b1;
      if (status.scan_end && cost_mode) short_in = (need_ff != '0);

      // cost scan over chunk summaries
      if (eval_v && cost_mode) begin
         if (fits) begin
            need_in       = need_after;
            cost_in       = cost_ff + COST_W'(prod_ff) + COST_W'(chk_rd_ff.cost);
            any_in        = 1'b1;
            last_price_in = {pend_idx_ff, highest_bit(chk_rd_ff.bitmap)};
         end else begin
            walk_base_in = pend_idx_ff;
            walk_map_in  = chk_rd_ff.bitmap;
            walk_cnt_in  = '0;
         end
      end

      // level walk inside the marginal chunk
      if (w_eval) begin
         if (w_lt) begin
            need_in = need_ff - TARGET_W'(lvl_rd_ff);
         end else begin
            mprice_in = w_pr;
            mused_in  = need_ff[AMT_W-1:0];
            mleft_in  = lvl_rd_ff - need_ff[AMT_W-1:0];
         end
      end

      // marginal level of the last fully used chunk
      if (cmd.last_eval) begin
         mprice_in = last_price_ff;
         mused_in  = lvl_rd_ff;
         mleft_in  = '0;
      end

      // result register
      if (cmd.latch) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, short_ff, mleft_ff, mused_ff, mprice_ff, cost_out,
                         empty_ff, best_ff, uf_ff, chk_emp_ff, lvl_emp_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff    <= TARGET_RESET;
         clr_cnt_ff   <= '0;
         scan_cnt_ff  <= '0;
         pend_v_ff    <= 1'b0;
         walk_cnt_ff  <= '0;
         lv_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         target_ff    <= target_in;
         clr_cnt_ff   <= clr_cnt_in;
         scan_cnt_ff  <= scan_cnt_in;
         pend_v_ff    <= pend_v_in;
         walk_cnt_ff  <= walk_cnt_in;
         lv_v_ff      <= lv_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      price_ff      <= price_in;
      amount_ff     <= amount_in;
      pend_idx_ff   <= pend_idx_in;
      lv_pos_ff     <= lv_pos_in;
      need_ff       <= need_in;
      cost_ff       <= cost_in;
      prod_ff       <= prod_in;
      any_ff        <= any_in;
      last_price_ff <= last_price_in;
      walk_base_ff  <= walk_base_in;
      walk_map_ff   <= walk_map_in;
      take_ff       <= take_in;
      lvl_new_ff    <= lvl_new_in;
      uf_ff         <= uf_in;
      lvl_emp_ff    <= lvl_emp_in;
      chk_emp_ff    <= chk_emp_in;
      best_ff       <= best_in;
      empty_ff      <= empty_in;
      mprice_ff     <= mprice_in;
      mused_ff      <= mused_in;
      mleft_ff      <= mleft_in;
      short_ff      <= short_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== rtl/order_book_level_aggregator_unit.sv =====
// order_book_level_aggregator_unit: one side of an order book with per-chunk summaries
// depends on obla_pkg, obla_ctrl and obla_dp
//
// Usage:
//   req channel carries one word per operation: tuser selects add, remove,
//   best price query or cost query; tdata holds price and amount.
//   rsp channel returns exactly one word per request with flags, best price,
//   total cost and the marginal level of the fill.
//   csr_wr_en/csr_wr_data load the target size used by cost queries (reset 100).
// Sequence from accept to rsp_tvalid; req_tready is high again in the cycle rsp_tvalid rises:
//   add or remove: level and chunk read, take and multiply, write back, latch.
//   best price query: chunks read up to the first occupied one, or all chunks
//   on an empty book.
//   cost query: chunk summaries one per cycle, then levels one per cycle in the
//   marginal chunk up to the position where the fill ends; on an exact chunk fill,
//   or a short fill after a fully used chunk, the last level of that chunk is read.
// Reset: a clearing pass writes zero to all 4096 level entries (and the 128
//   chunk entries); req_tready stays low until it ends.
// Stall: the result waits in an output register; while rsp_tready is low the
//   next request is taken and worked on but its result is held back.
`timescale 1ns / 1ps

module order_book_level_aggregator_unit import obla_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // price[11:0], amount[35:12], zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode[1:0]
   input  logic [MODE_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // level_emptied[0], chunk_emptied[1], underflow[2], best_price[14:3],
   // book_empty[15], total_cost[63:16], marginal_price[75:64],
   // marginal_used[99:76], marginal_left[123:100], short_fill[124], zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [TARGET_W-1:0]   csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   obla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (mode_type'(req_tuser)),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // memories and arithmetic
   obla_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

endmodule

// ===== tb/tb_order_book_level_aggregator_unit.sv =====
// tb_order_book_level_aggregator_unit: self-checking bench for the order book level aggregator
// depends on obla_pkg and order_book_level_aggregator_unit; holds its own book predictor
`timescale 1ns / 1ps

module tb_order_book_level_aggregator_unit;
   import obla_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE      = 250;
   localparam int HOLD_LEN    = 3000;

   // one result word, highest field first
   typedef struct packed {
      logic              short_fill;
      logic [AMT_W-1:0]  marginal_left;
      logic [AMT_W-1:0]  marginal_used;
      logic [PRICE_W-1:0] marginal_price;
      logic [COST_W-1:0] total_cost;
      logic              book_empty;
      logic [PRICE_W-1:0] best_price;
      logic              underflow;
      logic              chunk_emptied;
      logic              level_emptied;
   } book_result_type;

   // book predictor and store of expected result words
   class book_scoreboard_type;
      logic [AMT_W-1:0]  level_amt [NUM_LEVELS];
      logic [LPC-1:0]    chunk_map [NUM_CHUNKS];
      longint unsigned   chunk_amt [NUM_CHUNKS];
      longint unsigned   chunk_cost [NUM_CHUNKS];
      longint unsigned   target;
      book_result_type   expected_q[$];
      int                errors;

      function new();
         target = TARGET_RESET;
         errors = 0;
         foreach (level_amt[i]) level_amt[i] = '0;
         foreach (chunk_map[i]) begin
            chunk_map[i] = '0;
            chunk_amt[i] = 0;
            chunk_cost[i] = 0;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // update the book for one accepted word and queue its result
      function void note_request(mode_type mode, logic [PRICE_W-1:0] price,
                                 logic [AMT_W-1:0] amount);
         book_result_type r;
         int ck, pos;
         longint unsigned held, take, need, cost, lv, pr, base, last_pr, last_amt;
         bit done, any, found;
         r = '0;
         ck = price / LPC;
         pos = price % LPC;
         held = level_amt[price];
         case (mode)
            MODE_ADD: begin
               take = (amount < AMT_MAX - held) ? amount : AMT_MAX - held;
               level_amt[price] = held + take;
               chunk_amt[ck] += take;
               chunk_cost[ck] += take * price;
               if (level_amt[price] != 0) chunk_map[ck][pos] = 1'b1;
            end
            MODE_REMOVE: begin
               take = amount;
               if (amount > held) begin
                  take = held;
                  r.underflow = 1'b1;
               end
               level_amt[price] = held - take;
               chunk_amt[ck] -= take;
               chunk_cost[ck] -= take * price;
               if (level_amt[price] == 0) begin
                  chunk_map[ck][pos] = 1'b0;
                  r.level_emptied = 1'b1;
                  if (chunk_amt[ck] == 0) r.chunk_emptied = 1'b1;
               end
            end
            MODE_BEST: begin
               found = 0;
               for (int c = 0; c < NUM_CHUNKS && !found; c++)
                  for (int p = 0; p < LPC && !found; p++)
                     if (chunk_map[c][p]) begin
                        r.best_price = c * LPC + p;
                        found = 1;
                     end
               if (!found) r.book_empty = 1'b1;
            end
            default: begin
               need = target;
               cost = 0;
               done = 0;
               any = 0;
               last_pr = 0;
               last_amt = 0;
               for (int c = 0; c < NUM_CHUNKS && !done; c++) begin
                  base = c * LPC;
                  if (chunk_map[c] == '0) continue;
                  if (chunk_amt[c] > need) begin
                     // marginal level lies inside this chunk
                     for (int p = 0; p < LPC && !done; p++) begin
                        if (!chunk_map[c][p]) continue;
                        pr = base + p;
                        lv = level_amt[pr];
                        if (lv < need) begin
                           need -= lv;
                           cost += lv * pr;
                        end else begin
                           cost += need * pr;
                           r.marginal_price = pr;
                           r.marginal_used = need;
                           r.marginal_left = lv - need;
                           done = 1;
                        end
                     end
                  end else begin
                     // whole chunk taken from its summary
                     need -= chunk_amt[c];
                     cost += chunk_cost[c];
                     any = 1;
                     for (int p = LPC - 1; p >= 0; p--)
                        if (chunk_map[c][p]) begin
                           last_pr = base + p;
                           last_amt = level_amt[last_pr];
                           break;
                        end
                     if (need == 0) begin
                        r.marginal_price = last_pr;
                        r.marginal_used = last_amt;
                        done = 1;
                     end
                  end
               end
               if (!done && need != 0) begin
                  r.short_fill = 1'b1;
                  if (any) begin
                     r.marginal_price = last_pr;
                     r.marginal_used = last_amt;
                  end
               end
               r.total_cost = cost;
            end
         endcase
         expected_q.push_back(r);
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         errors++;
         $display("mismatch %s: got %0h expected %0h", what, got, want);
      endtask

      // compare one result word with the oldest expectation
      task check_response(logic [RSP_DATA_W-1:0] word);
         book_result_type g, e;
         if (expected_q.size() == 0) begin
            report("unexpected word", word[63:0], 0);
            return;
         end
         g = word[$bits(book_result_type)-1:0];
         e = expected_q.pop_front();
         if (g.level_emptied !== e.level_emptied)
            report("level_emptied", g.level_emptied, e.level_emptied);
         if (g.chunk_emptied !== e.chunk_emptied)
            report("chunk_emptied", g.chunk_emptied, e.chunk_emptied);
         if (g.underflow !== e.underflow) report("underflow", g.underflow, e.underflow);
         if (g.best_price !== e.best_price) report("best_price", g.best_price, e.best_price);
         if (g.book_empty !== e.book_empty) report("book_empty", g.book_empty, e.book_empty);
         if (g.total_cost !== e.total_cost) report("total_cost", g.total_cost, e.total_cost);
         if (g.marginal_price !== e.marginal_price)
            report("marginal_price", g.marginal_price, e.marginal_price);
         if (g.marginal_used !== e.marginal_used)
            report("marginal_used", g.marginal_used, e.marginal_used);
         if (g.marginal_left !== e.marginal_left)
            report("marginal_left", g.marginal_left, e.marginal_left);
         if (g.short_fill !== e.short_fill) report("short_fill", g.short_fill, e.short_fill);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [MODE_W-1:0]     req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [TARGET_W-1:0]   csr_wr_data = '0;

   book_scoreboard_type book = new();
   bit  steady = 0;      // no idling on either side
   bit  hold_start = 0;  // long receiver hold-off request
   bit  hold_armed = 1;
   int  hold_left = 0;
   int  cycle_count = 0;
   int  window_chunk = 0;

   order_book_level_aggregator_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // long hold-off counter
   always @(posedge clock) begin
      if (hold_start && hold_armed) begin
         hold_left  <= HOLD_LEN;
         hold_armed <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int gap_length();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // result side: random stalls, long hold-off on request
   always @(posedge clock) begin
      int stall_left;
      if (rsp_tvalid && rsp_tready) book.check_response(rsp_tdata);
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (!reset && !steady) stall_left = gap_length();
      end
   end

   // offer one word and wait for it to be taken
   task automatic send_word(mode_type mode, logic [PRICE_W-1:0] price,
                            logic [AMT_W-1:0] amount);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {{(REQ_DATA_W - AMT_W - PRICE_W){1'b0}}, amount, price};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      book.note_request(mode, price, amount);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register write while the block is idle
   task automatic set_target(logic [TARGET_W-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      book.target = value;
   endtask

   // random word, mostly around a window of chunks so the book gets deep
   task automatic random_word();
      int r;
      logic [PRICE_W-1:0] price;
      logic [AMT_W-1:0] amount;
      longint unsigned held;
      if ($urandom_range(0, 99) < 85)
         price = PRICE_W'(window_chunk * LPC + $urandom_range(0, 4 * LPC - 1));
      else
         price = PRICE_W'($urandom);
      held = book.level_amt[price];
      r = $urandom_range(0, 99);
      if (r < 40) begin
         r = $urandom_range(0, 99);
         amount = (r < 70) ? AMT_W'($urandom_range(1, 5000)) :
                  (r < 90) ? AMT_W'($urandom) : AMT_MAX;
         send_word(MODE_ADD, price, amount);
      end else if (r < 70) begin
         r = $urandom_range(0, 99);
         if (r < 50) amount = held;
         else if (r < 75) amount = AMT_W'($urandom_range(0, int'(held)));
         else if (r < 90) amount = (held == AMT_MAX) ? AMT_MAX : AMT_W'(held + 1);
         else amount = AMT_W'($urandom);
         send_word(MODE_REMOVE, price, amount);
      end else if (r < 80)
         send_word(MODE_BEST, PRICE_W'($urandom), AMT_W'($urandom));
      else
         send_word(MODE_COST, PRICE_W'($urandom), AMT_W'($urandom));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty book, zero add, saturation, underflow, emptied chunk
      send_word(MODE_ADD, 12'd5, 24'd0);
      send_word(MODE_BEST, 12'd0, 24'd0);
      send_word(MODE_COST, 12'd0, 24'd0);
      send_word(MODE_REMOVE, 12'd3000, 24'd0);
      send_word(MODE_ADD, 12'd0, 24'd10);
      send_word(MODE_ADD, 12'd4095, AMT_MAX);
      send_word(MODE_ADD, 12'd4095, AMT_MAX);
      send_word(MODE_ADD, 12'd2000, 24'd50);
      send_word(MODE_BEST, 12'd0, 24'd0);
      send_word(MODE_COST, 12'd0, 24'd0);
      send_word(MODE_REMOVE, 12'd4095, 24'd1);
      send_word(MODE_REMOVE, 12'd4095, AMT_MAX);
      send_word(MODE_REMOVE, 12'd0, 24'd10);
      send_word(MODE_BEST, 12'hfff, AMT_MAX);
      send_word(MODE_COST, 12'd0, 24'd0);
      set_target(32'd0);
      send_word(MODE_COST, 12'd0, 24'd0);
      set_target(32'hffffffff);
      send_word(MODE_COST, 12'd0, 24'd0);
      set_target(32'd50);
      send_word(MODE_ADD, 12'd64, 24'd20);
      send_word(MODE_ADD, 12'd70, 24'd30);
      send_word(MODE_COST, 12'd0, 24'd0);
      send_word(MODE_REMOVE, 12'd2000, 24'd50);
      send_word(MODE_COST, 12'd0, 24'd0);

      // random phases over several target sizes
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: set_target(TARGET_W'($urandom_range(1, 200000)));
            1: set_target(32'd0);
            2: set_target(32'hffffffff);
            3: set_target(TARGET_W'($urandom));
            default: set_target(TARGET_W'($urandom_range(1, 20000000)));
         endcase
         window_chunk = $urandom_range(0, NUM_CHUNKS - 4);
         steady = (phase == 3);
         for (int n = 0; n < 265; n++) begin
            if (phase == 1 && n == 100) hold_start = 1'b1;
            if (phase == 2 && n == 130) begin
               req_tvalid <= 1'b0;
               while (book.pending() != 0) @(posedge clock);
            end
            random_word();
         end
         steady = 0;
      end

      drain();
      if (book.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
